// ===== sv/lphs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lphs_pkg;

  localparam int CAPACITY   = 1024;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = IDX_W + 1;
  localparam int KEY_W      = 64;
  localparam int LOAD_LIMIT = (CAPACITY * 3) / 4;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISSING  = 3'd3,
    ST_FULL     = 3'd4,
    ST_ZERO     = 3'd5
  } status_t;

  typedef struct packed {
    logic    load;
    logic    adv;
    logic    wr_key;
    logic    clr_wr;
    logic    cnt_inc;
    logic    res_valid;
    status_t res_status;
    logic    res_present;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
    logic func;
    logic hit;
    logic empty;
    logic full;
    logic clr_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/lphs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lphs_ctrl
  import lphs_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.res_status  = ST_ZERO;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (sts.in_zero) begin
            cmd.res_valid  = 1'b1;
            cmd.res_status = ST_ZERO;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.hit) begin
          cmd.res_valid   = 1'b1;
          cmd.res_present = 1'b1;
          cmd.res_status  = sts.func ? ST_FOUND : ST_DUP;
          state_next      = S_IDLE;
        end else if (sts.empty) begin
          cmd.res_valid = 1'b1;
          state_next    = S_IDLE;
          if (sts.func) begin
            cmd.res_status = ST_MISSING;
          end else if (sts.full) begin
            cmd.res_status = ST_FULL;
          end else begin
            cmd.res_status  = ST_INSERTED;
            cmd.res_present = 1'b1;
            cmd.wr_key      = 1'b1;
            cmd.cnt_inc     = 1'b1;
          end
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/lphs_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lphs_dp
  import lphs_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              func,
  input  wire  [KEY_W-1:0] key,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             done,
  output logic [2:0]       status,
  output logic             present,
  output logic [CNT_W-1:0] entries_held
);

  logic [KEY_W-1:0] mem [CAPACITY];
  logic [KEY_W-1:0] rd_data;
  logic [KEY_W-1:0] key_q;
  logic             func_q;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] clr_idx;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] home;

  assign home = key[IDX_W-1:0] ^ key[IDX_W+3:4];

  assign sts.in_zero  = (key == '0);
  assign sts.func     = func_q;
  assign sts.hit      = (rd_data == key_q);
  assign sts.empty    = (rd_data == '0);
  assign sts.full     = (count >= CNT_W'(LOAD_LIMIT));
  assign sts.clr_last = (clr_idx == {IDX_W{1'b1}});

  assign entries_held = count;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_idx] <= '0;
    end else if (cmd.wr_key) begin
      mem[idx] <= key_q;
    end
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q  <= key;
      func_q <= func;
      idx    <= home;
    end else if (cmd.adv) begin
      idx <= idx + 1'b1;
    end
    if (cmd.res_valid) begin
      status  <= cmd.res_status;
      present <= cmd.res_present;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      done <= cmd.res_valid;
      if (cmd.clr_wr) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/linear_probe_hash_set.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Set of nonzero 64-bit keys in a 1024-slot linear-probe table. After reset the
// table is cleared one slot per cycle, with busy high until the last slot is
// cleared. A transfer in is taken when start is high and busy is low. A zero
// key is answered in the cycle after start; any other key is answered after
// its probe, each slot probed costing one read of the table (S_READ) and then
// a compare (S_CHECK). The result shows for one cycle with done high and
// cannot be held off; entries_held always shows the current count. Inserts
// past 768 keys are refused with the full status.
module linear_probe_hash_set
  import lphs_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  input  wire              func,
  input  wire  [KEY_W-1:0] key,
  output logic             done,
  output logic [2:0]       status,
  output logic             present,
  output logic [CNT_W-1:0] entries_held
);

  cmd_t cmd;
  sts_t sts;

  lphs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  lphs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .func         (func),
    .key          (key),
    .cmd          (cmd),
    .sts          (sts),
    .done         (done),
    .status       (status),
    .present      (present),
    .entries_held (entries_held)
  );

endmodule
`default_nettype wire
